@@ design/ted_pkg.sv @@
// shared types, constants and helpers for the text encoding detector
`default_nettype none

package ted_pkg;

    // field and window sizes
    localparam int BYTE_W    = 8;
    localparam int LIMIT_W   = 16;
    localparam int WIN_DEPTH = 5;
    localparam int HOLD      = WIN_DEPTH - 1;
    localparam int FILL_W    = 3;
    localparam int SKIP_W    = 2;
    localparam int EXT_DEPTH = 2 * WIN_DEPTH - 1;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SCAN_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RST = LIMIT_W'(8 * 1024);

    // byte thresholds
    localparam logic [BYTE_W-1:0] B_OTHER  = 8'hFD;
    localparam logic [BYTE_W-1:0] B_LEAD4  = 8'hF0;
    localparam logic [BYTE_W-1:0] B_LEAD3  = 8'hE0;
    localparam logic [BYTE_W-1:0] B_LEAD2  = 8'hC0;
    localparam logic [BYTE_W-1:0] B_CONT   = 8'h80;
    localparam logic [BYTE_W-1:0] B_SJ_LO  = 8'h81;
    localparam logic [BYTE_W-1:0] B_SJ_HI  = 8'h9F;
    localparam logic [BYTE_W-1:0] B_SJ2_HI = 8'hEF;
    localparam logic [BYTE_W-1:0] B_TRAIL  = 8'h40;
    localparam logic [BYTE_W-1:0] B_DEL    = 8'h7F;

    // result codes
    typedef enum logic [1:0] {
        ENC_UTF8    = 2'd0,
        ENC_SJIS    = 2'd1,
        ENC_OTHER   = 2'd2,
        ENC_UNKNOWN = 2'd3
    } t_enc_class;

    // one inspected position and its four followers
    typedef logic [WIN_DEPTH-1:0][BYTE_W-1:0] t_win;

    // scan state carried from one position to the next
    typedef struct packed {
        logic [SKIP_W-1:0]  skip;
        logic [LIMIT_W-1:0] pos;
        logic               u8_out;
        logic               sj_out;
        logic               other;
    } t_scan;

    // utf-8 continuation byte
    function automatic logic is_cont(input logic [BYTE_W-1:0] b);
        is_cont = (b >= B_CONT) && (b < B_LEAD2);
    endfunction

endpackage

`default_nettype wire

@@ design/ted_inspect.sv @@
// inspection cell: applies the classification rules to one byte position
`default_nettype none

module ted_inspect (
    input  wire logic                          i_enable,
    input  wire logic [ted_pkg::LIMIT_W-1:0]   i_scan_limit,
    input  wire ted_pkg::t_win                 i_win,
    input  wire ted_pkg::t_scan                i_state,
    output ted_pkg::t_scan                     o_state
);

    logic [ted_pkg::BYTE_W-1:0] lead;
    logic                       u8_lead;
    logic                       u8_match;
    logic [ted_pkg::SKIP_W-1:0] u8_skip;
    logic                       u8_bad;
    logic                       sj_lead;
    logic                       sj_ok;

    assign lead = i_win[0];

    // utf-8 lead and continuation pattern
    always_comb begin
        u8_lead  = lead >= ted_pkg::B_LEAD2;
        u8_match = 1'b0;
        u8_skip  = '0;
        priority if (lead >= ted_pkg::B_LEAD4) begin
            u8_match = ted_pkg::is_cont(i_win[1]) && ted_pkg::is_cont(i_win[2])
                    && ted_pkg::is_cont(i_win[3]) && !ted_pkg::is_cont(i_win[4]);
            u8_skip  = ted_pkg::SKIP_W'(3);
        end else if (lead >= ted_pkg::B_LEAD3) begin
            u8_match = ted_pkg::is_cont(i_win[1]) && ted_pkg::is_cont(i_win[2])
                    && !ted_pkg::is_cont(i_win[3]);
            u8_skip  = ted_pkg::SKIP_W'(2);
        end else if (lead >= ted_pkg::B_LEAD2) begin
            u8_match = ted_pkg::is_cont(i_win[1]) && !ted_pkg::is_cont(i_win[2]);
            u8_skip  = ted_pkg::SKIP_W'(1);
        end else begin
            u8_match = 1'b0;
            u8_skip  = '0;
        end
        u8_bad = (u8_lead && !u8_match) || ted_pkg::is_cont(lead);
    end

    // shift-jis lead and trail byte
    assign sj_lead = ((lead >= ted_pkg::B_SJ_LO) && (lead <= ted_pkg::B_SJ_HI))
                  || ((lead >= ted_pkg::B_LEAD3) && (lead <= ted_pkg::B_SJ2_HI));
    assign sj_ok   = (i_win[1] >= ted_pkg::B_TRAIL) && (i_win[1] != ted_pkg::B_DEL)
                  && (i_win[1] < ted_pkg::B_OTHER);

    // state update for one position
    always_comb begin
        logic u8n;
        logic sjn;
        o_state = i_state;
        u8n     = i_state.u8_out | u8_bad;
        sjn     = i_state.sj_out | sj_lead;
        if (i_enable && !i_state.other && (i_state.pos < i_scan_limit)) begin
            o_state.pos = i_state.pos + 1'b1;
            priority if (i_state.skip != '0) begin
                o_state.skip = i_state.skip - 1'b1;
            end else if (lead >= ted_pkg::B_OTHER) begin
                o_state.other = 1'b1;
            end else if (!i_state.u8_out && u8_lead && u8_match) begin
                o_state.skip = u8_skip;
            end else if (!i_state.sj_out && sj_lead && sj_ok) begin
                o_state.u8_out = u8n;
                o_state.skip   = ted_pkg::SKIP_W'(1);
            end else begin
                o_state.u8_out = u8n;
                o_state.sj_out = sjn;
                o_state.other  = u8n & sjn;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/text_encoding_detector_unit.sv @@
// top level of the utf-8 / shift-jis text encoding detector
//
//  channel   direction  handshake                  payload
//  in        to block   i_in_valid / o_in_stall    i_data_byte, i_end_of_data
//  out       from block o_out_valid / i_out_stall  o_encoding_class
//  config    to block   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one byte item a cycle unless a last item waits: input register, one pass of five inspection cells, result register
// an accepted last byte goes through the input register and the chained cells into the result register
// the final item drains up to five positions through the chained cells in the cycle that it is processed
// a waiting result stalls only a last item; other bytes keep flowing
// reset is synchronous, active low, and needs no clearing pass
`default_nettype none

module text_encoding_detector_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [ted_pkg::BYTE_W-1:0]    i_data_byte,
    input  wire logic                          i_end_of_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [1:0]                         o_encoding_class,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ted_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ted_pkg::PDATA_W-1:0]   pwdata,
    output logic [ted_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int NC = ted_pkg::WIN_DEPTH;

    logic [ted_pkg::LIMIT_W-1:0]                r_scan_limit;
    logic                                       r_in_vld;
    logic [ted_pkg::BYTE_W-1:0]                 r_in_byte;
    logic                                       r_in_last;
    logic [ted_pkg::HOLD-1:0][ted_pkg::BYTE_W-1:0] r_win;
    logic [ted_pkg::HOLD-1:0][ted_pkg::BYTE_W-1:0] n_win;
    logic [ted_pkg::FILL_W-1:0]                 r_fill;
    logic [ted_pkg::FILL_W-1:0]                 n_fill;
    ted_pkg::t_scan                             r_scan;
    ted_pkg::t_scan                             n_scan;
    logic                                       r_out_vld;
    ted_pkg::t_enc_class                        r_class;
    ted_pkg::t_enc_class                        n_class;

    logic                                       in_acc;
    logic                                       proc;
    logic                                       cfg_wr;
    logic [ted_pkg::FILL_W-1:0]                 count;
    logic [ted_pkg::EXT_DEPTH-1:0][ted_pkg::BYTE_W-1:0] ext;
    logic [NC-1:0]                              cell_en;
    ted_pkg::t_scan                             chain [NC+1];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == ted_pkg::REG_SCAN_LIMIT)
                  ? ted_pkg::PDATA_W'(r_scan_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_limit <= ted_pkg::SCAN_LIMIT_RST;
        end else if (cfg_wr && (paddr[2] == ted_pkg::REG_SCAN_LIMIT)) begin
            r_scan_limit <= pwdata[ted_pkg::LIMIT_W-1:0];
        end
    end

    // handshake: only a last item waits for the result register
    assign proc        = r_in_vld && (!r_in_last || !r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !proc;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_encoding_class = r_class;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_end_of_data;
        end
    end

    // held bytes, new byte, then zero padding past the end
    always_comb begin
        ext = '0;
        for (int j = 0; j < ted_pkg::HOLD; j++) begin
            if (ted_pkg::FILL_W'(j) < r_fill) begin
                ext[j] = r_win[j];
            end else if (ted_pkg::FILL_W'(j) == r_fill) begin
                ext[j] = r_in_byte;
            end
        end
        if (r_fill == ted_pkg::FILL_W'(ted_pkg::HOLD)) begin
            ext[ted_pkg::HOLD] = r_in_byte;
        end
    end

    // which cells inspect a position this cycle
    assign count = r_fill + 1'b1;
    always_comb begin
        for (int k = 0; k < NC; k++) begin
            if (r_in_last) begin
                cell_en[k] = proc && (ted_pkg::FILL_W'(k) < count);
            end else begin
                cell_en[k] = proc && (k == 0) && (r_fill == ted_pkg::FILL_W'(ted_pkg::HOLD));
            end
        end
    end

    // chain of inspection cells
    assign chain[0] = r_scan;
    for (genvar k = 0; k < NC; k++) begin : g_cell
        ted_inspect u_inspect (
            .i_enable     (cell_en[k]),
            .i_scan_limit (r_scan_limit),
            .i_win        (ext[k+ted_pkg::WIN_DEPTH-1:k]),
            .i_state      (chain[k]),
            .o_state      (chain[k+1])
        );
    end

    // next window, fill and scan state
    always_comb begin
        n_win   = r_win;
        n_fill  = r_fill;
        n_scan  = r_scan;
        if (r_in_last) begin
            n_win  = r_win;
            n_fill = '0;
            n_scan = '0;
        end else if (r_fill == ted_pkg::FILL_W'(ted_pkg::HOLD)) begin
            for (int j = 0; j < ted_pkg::HOLD - 1; j++) begin
                n_win[j] = r_win[j+1];
            end
            n_win[ted_pkg::HOLD-1] = r_in_byte;
            n_scan = chain[NC];
        end else begin
            for (int j = 0; j < ted_pkg::HOLD; j++) begin
                if (ted_pkg::FILL_W'(j) == r_fill) begin
                    n_win[j] = r_in_byte;
                end
            end
            n_fill = r_fill + 1'b1;
        end
    end

    // verdict from the fully drained state
    always_comb begin
        priority if (chain[NC].other) begin
            n_class = ted_pkg::ENC_OTHER;
        end else if (chain[NC].u8_out) begin
            n_class = ted_pkg::ENC_SJIS;
        end else if (chain[NC].sj_out) begin
            n_class = ted_pkg::ENC_UTF8;
        end else begin
            n_class = ted_pkg::ENC_UNKNOWN;
        end
    end

    // scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_scan <= '0;
        end else if (proc) begin
            r_fill <= n_fill;
            r_scan <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (proc) begin
            r_win <= n_win;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_last) begin
            r_class <= n_class;
        end
    end

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= ted_pkg::FILL_W'(ted_pkg::HOLD))
        else $error("window fill beyond four held bytes");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(proc && r_in_last))
        else $error("result raised without a last item");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_last |=> (r_fill == '0) && (r_scan.pos == '0) && !r_scan.other)
        else $error("scan state not cleared after last item");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_in_last && r_out_vld && i_out_stall |-> o_in_stall && !proc)
        else $error("waiting result would be overwritten");

endmodule

`default_nettype wire

@@ tb/encoding_verdict_checker.sv @@
// checker for the text encoding detector: predicts each file verdict and compares results
`default_nettype none

module encoding_verdict_checker
    import ted_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [BYTE_W-1:0]    i_data_byte,
    input  wire logic                 i_end_of_data,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [1:0]           i_encoding_class,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    input  wire logic [PDATA_W-1:0]   prdata,
    input  wire logic                 pready,
    output int                        o_mismatches,
    output int                        o_pending
);

    // predicted scan state and register copy
    logic [BYTE_W-1:0]  look [WIN_DEPTH];
    logic [FILL_W-1:0]  fill;
    logic [SKIP_W-1:0]  skip_left;
    logic [LIMIT_W-1:0] scanned;
    logic [LIMIT_W-1:0] scan_limit;
    logic               u8_out;
    logic               sj_out;
    logic               other;
    t_enc_class         class_due [$];
    t_enc_class         got_class;

    initial o_mismatches = 0;
    initial o_pending = 0;

    function automatic logic cont_byte(input logic [BYTE_W-1:0] b);
        return (b >= B_CONT) && (b < B_LEAD2);
    endfunction

    function automatic logic sjis_lead(input logic [BYTE_W-1:0] b);
        return (b >= B_SJ_LO && b <= B_SJ_HI) || (b >= B_LEAD3 && b <= B_SJ2_HI);
    endfunction

    // clear the scan state; the register copy and the expected verdicts are kept
    function void clear_scan();
        for (int k = 0; k < WIN_DEPTH; k++) look[k] = '0;
        fill = '0;
        skip_left = '0;
        scanned = '0;
        u8_out = 1'b0;
        sj_out = 1'b0;
        other = 1'b0;
    endfunction

    // inspect the oldest held position against its four followers
    function void scan_head();
        logic [BYTE_W-1:0] c;
        c = look[0];
        if (other || scanned >= scan_limit) return;
        scanned = scanned + 1'b1;
        if (skip_left != '0) begin
            skip_left = skip_left - 1'b1;
            return;
        end
        if (c >= B_OTHER) begin
            other = 1'b1;
            return;
        end
        if (!u8_out) begin
            if (c >= B_LEAD4) begin
                if (cont_byte(look[1]) && cont_byte(look[2]) && cont_byte(look[3])
                        && !cont_byte(look[4])) begin
                    skip_left = 2'd3;
                    return;
                end
                u8_out = 1'b1;
            end else if (c >= B_LEAD3) begin
                if (cont_byte(look[1]) && cont_byte(look[2]) && !cont_byte(look[3])) begin
                    skip_left = 2'd2;
                    return;
                end
                u8_out = 1'b1;
            end else if (c >= B_LEAD2) begin
                if (cont_byte(look[1]) && !cont_byte(look[2])) begin
                    skip_left = 2'd1;
                    return;
                end
                u8_out = 1'b1;
            end else if (cont_byte(c)) begin
                u8_out = 1'b1;
            end
        end
        if (!sj_out && sjis_lead(c)) begin
            if (look[1] < B_TRAIL || look[1] == B_DEL || look[1] >= B_OTHER) begin
                sj_out = 1'b1;
            end else begin
                skip_left = 2'd1;
                return;
            end
        end
        if (u8_out && sj_out) other = 1'b1;
    endfunction

    // drop the head position and pad with zero
    function void advance();
        for (int k = 0; k < HOLD; k++) look[k] = look[k+1];
        look[HOLD] = '0;
        if (fill != '0) fill = fill - 1'b1;
    endfunction

    function t_enc_class file_verdict();
        if (other) return ENC_OTHER;
        if (u8_out) return ENC_SJIS;
        if (sj_out) return ENC_UTF8;
        return ENC_UNKNOWN;
    endfunction

    // one accepted byte item; the last byte flushes the window and yields a verdict
    function void take_byte(input logic [BYTE_W-1:0] b, input logic last);
        if (fill >= WIN_DEPTH) fill = FILL_W'(HOLD);
        look[fill] = b;
        fill = fill + 1'b1;
        if (fill == WIN_DEPTH) begin
            scan_head();
            advance();
        end
        if (last) begin
            for (int k = 0; k < WIN_DEPTH; k++) if (k >= fill) look[k] = '0;
            while (fill != '0) begin
                scan_head();
                advance();
            end
            class_due.push_back(file_verdict());
            clear_scan();
        end
    endfunction

    // watch the channels and the register port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_limit = SCAN_LIMIT_RST;
            clear_scan();
            class_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got_class = t_enc_class'(i_encoding_class);
                if (class_due.size() == 0) begin
                    $display("%0t: unexpected verdict, expected none, actual %0d",
                             $time, i_encoding_class);
                    o_mismatches = o_mismatches + 1;
                end else if (got_class !== class_due[0]) begin
                    $display("%0t: verdict mismatch, expected %0d, actual %0d",
                             $time, class_due[0], i_encoding_class);
                    o_mismatches = o_mismatches + 1;
                    void'(class_due.pop_front());
                end else begin
                    void'(class_due.pop_front());
                end
            end
            if (i_in_valid && !i_in_stall) take_byte(i_data_byte, i_end_of_data);
            if (psel && penable && pready && (paddr >> 2) == PADDR_W'(REG_SCAN_LIMIT)) begin
                if (pwrite) begin
                    scan_limit = pwdata[LIMIT_W-1:0];
                end else if (prdata[LIMIT_W-1:0] !== scan_limit) begin
                    $display("%0t: scan limit readback, expected %0d, actual %0d",
                             $time, scan_limit, prdata[LIMIT_W-1:0]);
                    o_mismatches = o_mismatches + 1;
                end
            end
        end
        o_pending = class_due.size();
    end

endmodule

`default_nettype wire

@@ tb/text_encoding_detector_unit_tb.sv @@
// testbench top for the text encoding detector: stimulus, idling and the verdict
`default_nettype none

module text_encoding_detector_unit_tb;
    import ted_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int SEG_BYTES   = 80;
    localparam logic [PADDR_W-1:0] ADDR_LIMIT = PADDR_W'(4 * REG_SCAN_LIMIT);
    localparam logic [PADDR_W-1:0] ADDR_NONE  = PADDR_W'(4 * (REG_SCAN_LIMIT + 1));

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [BYTE_W-1:0]   data_byte = '0;
    logic                end_of_data = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          enc_class;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    int                  mismatches;
    int                  pending;
    int                  tx_gap_pct = 25;
    int                  rx_stall_pct = 68;
    int                  rand_bytes = 0;
    int                  cycle_count = 0;
    logic [BYTE_W-1:0]   file_text [$];
    logic [PDATA_W-1:0]  limit_words [10];

    always #6 clk = ~clk;

    text_encoding_detector_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_data_byte(data_byte), .i_end_of_data(end_of_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_encoding_class(enc_class),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    encoding_verdict_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_data_byte(data_byte), .i_end_of_data(end_of_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_encoding_class(enc_class),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .o_mismatches(mismatches), .o_pending(pending)
    );

    // receiver stalls at random
    always @(negedge clk) out_stall = ($urandom_range(99) < rx_stall_pct);

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // one register access, setup then access cycle
    task apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                    input logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // one byte item, with random sender gaps
    task send_byte(input logic [BYTE_W-1:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < tx_gap_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        data_byte = b;
        end_of_data = last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task send_file();
        for (int i = 0; i < file_text.size(); i++)
            send_byte(file_text[i], i == file_text.size() - 1);
    endtask

    // wait for the last verdict and let the block settle before a register write
    task wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (6) @(negedge clk);
    endtask

    // random file: mostly well-formed utf-8 or shift-jis text, some noise and damage
    task make_file();
        int len;
        int style;
        int r;
        logic [BYTE_W-1:0] trail;
        file_text.delete();
        len = ($urandom_range(11) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 16);
        style = $urandom_range(9);
        while (file_text.size() < len) begin
            r = $urandom_range(9);
            if (style == 8 || r == 9) begin
                file_text.push_back(BYTE_W'($urandom_range(255)));
            end else if (r < 4) begin
                file_text.push_back(BYTE_W'($urandom_range(127)));
            end else if (style < 4 || style == 9 || (style == 7 && r[0])) begin
                // utf-8 sequence of two, three or four bytes
                if (r < 6) begin
                    file_text.push_back(B_LEAD2 + BYTE_W'($urandom_range(31)));
                end else if (r < 8) begin
                    file_text.push_back(B_LEAD3 + BYTE_W'($urandom_range(15)));
                    file_text.push_back(B_CONT + BYTE_W'($urandom_range(63)));
                end else begin
                    file_text.push_back(B_LEAD4 + BYTE_W'($urandom_range(12)));
                    file_text.push_back(B_CONT + BYTE_W'($urandom_range(63)));
                    file_text.push_back(B_CONT + BYTE_W'($urandom_range(63)));
                end
                file_text.push_back(B_CONT + BYTE_W'($urandom_range(63)));
            end else if (r < 7) begin
                // shift-jis double-byte character
                if ($urandom_range(1) == 0)
                    file_text.push_back(B_SJ_LO + BYTE_W'($urandom_range(30)));
                else
                    file_text.push_back(B_LEAD3 + BYTE_W'($urandom_range(15)));
                trail = BYTE_W'($urandom_range(8'h40, 8'hFC));
                if (trail == B_DEL) trail = B_CONT;
                file_text.push_back(trail);
            end else begin
                // half-width kana
                file_text.push_back(BYTE_W'($urandom_range(8'hA1, 8'hDF)));
            end
        end
        if (style == 9)
            file_text[$urandom_range(file_text.size() - 1)] = BYTE_W'($urandom_range(255));
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed files at the reset scan limit
        file_text = '{8'h00};                        send_file();
        file_text = '{8'hFF};                        send_file();
        file_text = '{8'hC3, 8'hA9};                 send_file();
        file_text = '{8'hE3, 8'h81, 8'h82};          send_file();
        file_text = '{8'hF0, 8'h9F, 8'h98, 8'h80};   send_file();
        file_text = '{8'h82, 8'hA0};                 send_file();
        file_text = '{8'h81, 8'h7F};                 send_file();
        file_text = '{8'hFD, 8'h41, 8'h42};          send_file();
        file_text = '{8'h7F, 8'h80};                 send_file();
        file_text = '{8'hE0, 8'hFC, 8'h40};          send_file();

        // scan limit settings, extremes among them; upper bits are dropped
        limit_words = '{32'd1, 32'h0001_0000, 32'd2, 32'd3, 32'hFFFF_FFFF,
                        32'd0, 32'd0, 32'd5, 32'h0000_2000, 32'd4};
        limit_words[5] = {16'($urandom), 16'($urandom_range(6, 40))};
        limit_words[6] = PDATA_W'($urandom_range(41, 65535));

        foreach (limit_words[s]) begin
            wait_idle();
            apb_access(1'b1, ADDR_LIMIT, limit_words[s]);
            apb_access(1'b1, ADDR_NONE, $urandom);
            apb_access(1'b0, ADDR_LIMIT, '0);
            for (int n = 0; n < SEG_BYTES; n += file_text.size()) begin
                make_file();
                send_file();
                rand_bytes += file_text.size();
                // idling phases
                if (rand_bytes >= 800) begin
                    tx_gap_pct = 0;
                    rx_stall_pct = 0;
                end else if (rand_bytes >= 400) begin
                    tx_gap_pct = 68;
                    rx_stall_pct = 25;
                end
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
